// File: rtl/core/dq_pkg.sv
package dq_pkg;

  localparam int DATA_W    = 32;
  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;
  localparam int DEPTH_DEF = 16;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] push_value;
  } dq_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       entry_count;
  } dq_res_t;

  // Outcome of one request, handed from the ring to the output side.
  typedef struct packed {
    logic                pop_ok;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } dq_info_t;

endpackage

// File: rtl/core/dq_ring.sv
module dq_ring #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             acc,
  input  dq_pkg::dq_req_t                  req,
  output dq_pkg::dq_info_t                 info,
  output logic signed [dq_pkg::DATA_W-1:0] rd_data
);
  import dq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(DEPTH);

  logic signed [DATA_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0] front;
  logic [IDX_W-1:0] front_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic             wr_en;
  logic             rd_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic             pop_ok;
  logic [STATUS_W-1:0] status;

  logic [CNT_W-1:0] off;
  logic [SUM_W-1:0] sum;
  logic [IDX_W-1:0] slot;
  logic [CNT_W+COUNT_W-1:0] count_wide;

  // Ring position that lies off places behind the front word; off is below DEPTH whenever the slot is used.
  always_comb begin
    off = (req.req_type == REQ_POP_BACK) ? (count - CNT_W'(1)) : count;
    sum = SUM_W'(front) + SUM_W'(off);
    if (sum >= SUM_DEPTH) begin
      sum = sum - SUM_DEPTH;
    end
    slot = sum[IDX_W-1:0];
  end

  always_comb begin
    front_next = front;
    count_next = count;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = slot;
    rd_addr    = slot;
    pop_ok     = 1'b0;
    status     = ST_DONE;
    case (req.req_type)
      REQ_PUSH_BACK: begin
        if (count == CNT_FULL) begin
          status = ST_OVERFLOW;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      REQ_PUSH_FRONT: begin
        if (count == CNT_FULL) begin
          status = ST_OVERFLOW;
        end else begin
          front_next = (front == '0) ? IDX_LAST : (front - IDX_W'(1));
          wr_en      = 1'b1;
          wr_addr    = front_next;
          count_next = count + CNT_W'(1);
        end
      end
      REQ_POP_BACK: begin
        if (count == '0) begin
          status = ST_UNDERFLOW;
        end else begin
          rd_en      = 1'b1;
          pop_ok     = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        if (count == '0) begin
          status = ST_UNDERFLOW;
        end else begin
          rd_en      = 1'b1;
          pop_ok     = 1'b1;
          rd_addr    = front;
          front_next = (front == IDX_LAST) ? '0 : (front + IDX_W'(1));
          count_next = count - CNT_W'(1);
        end
      end
    endcase
    count_wide = {{COUNT_W{1'b0}}, count_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (acc) begin
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      info.pop_ok <= pop_ok;
      info.status <= status;
      info.count  <= count_wide[COUNT_W-1:0];
    end
  end

  // One request touches one entry, so a write and a read never meet in a cycle.
  always_ff @(posedge clk) begin
    if (acc && wr_en) begin
      mem[wr_addr] <= req.push_value;
    end
    if (acc && rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/double_ended_queue.sv
// Double-ended queue of signed 32-bit words kept in a ring memory of DEPTH entries.
// Requests arrive as beats on the req channel (req_valid, req_stall, req): push at
// the back, push at the front, pop from the back or pop from the front.
// Every request beat yields exactly one beat on the res channel (res_valid,
// res_stall, res) carrying the popped word (zero unless a pop succeeded), a status
// code (done, underflow, overflow) and the number of stored words afterwards.
// A pop on an empty queue reports underflow and a push on a full ring reports
// overflow; neither changes the queue.
// An accepted request passes through the ring's registers (memory read data and
// outcome) and then the output register before its result beat. One request per
// cycle is taken while the receiver does not stall; each uses one memory access.
// When the receiver stalls, the output register holds its beat, one further
// request may be accepted and parked behind it, and req_stall is then raised.
// Synchronous reset empties the queue and drops any beats in flight; the memory
// contents are not cleared and no word is ever read before it was written.
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  dq_pkg::dq_req_t req,
  output logic            res_valid,
  input  logic            res_stall,
  output dq_pkg::dq_res_t res
);
  import dq_pkg::*;

  localparam logic [COUNT_W-1:0] DEPTH_TRUNC = COUNT_W'(DEPTH);

  // An accepted request whose ring step has completed but whose result has not yet
  // moved into the output register.
  logic p_valid;
  logic acc;
  logic move;

  dq_info_t                 info;
  logic signed [DATA_W-1:0] rd_data;

  // The pending result moves out whenever the output register is empty or
  // its beat is being taken this cycle.
  assign move      = p_valid && (!res_valid || !res_stall);
  assign req_stall = p_valid && !move;
  assign acc       = req_valid && !req_stall;

  dq_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .req     (req),
    .info    (info),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (acc) begin
        p_valid <= 1'b1;
      end else if (move) begin
        p_valid <= 1'b0;
      end
      if (move) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload; the memory read data is only meaningful after a good pop.
  always_ff @(posedge clk) begin
    if (move) begin
      res.popped_value <= info.pop_ok ? rd_data : '0;
      res.status       <= info.status;
      res.entry_count  <= info.count;
    end
  end

`ifndef SYNTH
  a_fail_no_word: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_DONE |-> res.popped_value == '0)
    else $error("failed request returned a nonzero word");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    p_valid && info.status == ST_UNDERFLOW |-> info.count == '0 && !info.pop_ok)
    else $error("underflow reported on a non-empty queue");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    p_valid && info.status == ST_OVERFLOW |-> info.count == DEPTH_TRUNC)
    else $error("overflow reported on a ring that is not full");

  a_pending_held: assert property (@(posedge clk) disable iff (rst)
    p_valid && !move |=> p_valid && $stable(info) && (!info.pop_ok || $stable(rd_data)))
    else $error("pending result lost while the output was stalled");
`endif

endmodule
